/* hw/rtl/assert_macros.svh */
// -----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/grs_pkg.sv */
// -----------------------------------------------------------------------------
// grs_pkg
// shared types and constants of the group reduction block
// -----------------------------------------------------------------------------
package grs_pkg;

  localparam int COEF_W = 32;
  localparam int LEN_W  = 17;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 32;

  localparam int          SAMPLE_WIDTH_DEF = 16;
  localparam int          ACC_WIDTH_DEF    = 48;
  localparam int unsigned MAX_GROUP_DEF    = 65536;

  localparam logic signed [COEF_W-1:0] COEF_RESET = 32'sh0100_0000;

  localparam logic [IDX_W-1:0] REG_OPERATION    = 2'd0;
  localparam logic [IDX_W-1:0] REG_COEFFICIENT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_GROUP_LENGTH = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_SUM   = 2'd0,
    OP_MEAN  = 2'd1,
    OP_ASUM  = 2'd2,
    OP_SUMSQ = 2'd3
  } op_t;

  typedef struct packed {
    logic cfg_write;
    logic take;
    logic div_init;
    logic div_step;
    logic scale_load;
    logic mag_load;
    logic mul_lo;
    logic mul_hi;
    logic prod_load;
    logic rnd_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic mean;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/grs_dp.sv */
// -----------------------------------------------------------------------------
// grs_dp
// registers, term stage, saturating accumulator, divider and scaling datapath
// -----------------------------------------------------------------------------
module grs_dp #(
  parameter int          SAMPLE_WIDTH = grs_pkg::SAMPLE_WIDTH_DEF,
  parameter int          ACC_WIDTH    = grs_pkg::ACC_WIDTH_DEF,
  parameter int unsigned MAX_GROUP    = grs_pkg::MAX_GROUP_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  grs_pkg::cmd_t                  cmd,
  output grs_pkg::status_t               status,
  input  logic [grs_pkg::IDX_W-1:0]      cfg_index,
  input  logic [grs_pkg::CFG_W-1:0]      cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [ACC_WIDTH-1:0]    value,
  output logic                           saturated
);
  import grs_pkg::*;

  localparam int TW        = 2 * SAMPLE_WIDTH - 7;
  localparam int SQW       = 2 * SAMPLE_WIDTH + 2;
  localparam int SUMW      = ((ACC_WIDTH > TW) ? ACC_WIDTH : TW) + 1;
  localparam int MUL_W     = 32;
  localparam int MAGW      = 2 * MUL_W;
  localparam int PROD_W    = MAGW + MUL_W;
  localparam int COEF_FRAC = 24;
  localparam int QW        = PROD_W - COEF_FRAC + 1;
  localparam int unsigned LEN_MAX   = (1 << LEN_W) - 1;
  localparam int unsigned MAXG_CLIP = (MAX_GROUP > LEN_MAX) ? LEN_MAX : MAX_GROUP;

  localparam logic [LEN_W-1:0] MAXG = LEN_W'(MAXG_CLIP);
  localparam logic signed [SUMW-1:0] SUM_MAX =
    {{(SUMW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic [QW-1:0] LIM_POS = {{(QW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = LIM_POS + QW'(1);

  op_t                      operation;
  logic signed [COEF_W-1:0] coefficient;
  logic [LEN_W-1:0]         glen;
  logic [LEN_W-1:0]         len_raw;
  logic [LEN_W-1:0]         len_fix;

  logic signed [COEF_W-1:0] scale;
  logic [COEF_W-1:0]        coef_mag;
  logic [COEF_W-1:0]        dq;
  logic [LEN_W-1:0]         rem;
  logic                     dsign;
  logic [LEN_W:0]           rem_sh;
  logic [LEN_W:0]           diff;
  logic                     ge;

  logic signed [SAMPLE_WIDTH:0] s_ext;
  logic [SAMPLE_WIDTH:0]        mag;
  logic [SQW-1:0]               sq;
  logic signed [TW-1:0]         term_d;
  logic signed [TW-1:0]         term_q;
  logic                         term_vld;
  logic [LEN_W-1:0]             count;
  logic [LEN_W:0]               cnt_inc;

  logic signed [ACC_WIDTH-1:0] acc;
  logic signed [ACC_WIDTH-1:0] acc_next;
  logic signed [SUMW-1:0]      sum;
  logic [ACC_WIDTH-1:0]        acc_mag;
  logic [COEF_W-1:0]           scale_mag;

  logic [MAGW-1:0]   am;
  logic [COEF_W-1:0] sm;
  logic              neg;
  logic [MUL_W-1:0]  mul_a;
  logic [MAGW-1:0]   mul_p;
  logic [MAGW-1:0]   p_lo;
  logic [MAGW-1:0]   p_hi;
  logic [PROD_W-1:0] prod;
  logic              rnd_up;
  logic [QW-1:0]     qr;
  logic [QW-1:0]     lim;
  logic              sat_d;
  logic [QW-1:0]     qsel;
  logic [ACC_WIDTH-1:0] res;

  // register file
  assign len_raw = cfg_data[LEN_W-1:0];

  always_comb begin
    if (len_raw == '0) begin
      len_fix = LEN_W'(1);
    end else if (len_raw > MAXG) begin
      len_fix = MAXG;
    end else begin
      len_fix = len_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation   <= OP_SUM;
      coefficient <= COEF_RESET;
      glen        <= LEN_W'(1);
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        REG_OPERATION:    operation   <= op_t'(cfg_data[OP_W-1:0]);
        REG_COEFFICIENT:  coefficient <= cfg_data[COEF_W-1:0];
        REG_GROUP_LENGTH: glen        <= len_fix;
        default: ;
      endcase
    end
  end

  // restoring divider for the mean scale, one quotient bit a cycle
  assign coef_mag = coefficient[COEF_W-1] ? COEF_W'(-coefficient) : COEF_W'(coefficient);
  assign rem_sh   = {rem, dq[COEF_W-1]};
  assign diff     = rem_sh - {1'b0, glen};
  assign ge       = !diff[LEN_W];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq    <= coef_mag;
      rem   <= '0;
      dsign <= coefficient[COEF_W-1];
    end else if (cmd.div_step) begin
      dq  <= {dq[COEF_W-2:0], ge};
      rem <= ge ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= COEF_RESET;
    end else if (cmd.div_init) begin
      scale <= coefficient;
    end else if (cmd.scale_load) begin
      scale <= dsign ? COEF_W'(-dq) : dq;
    end
  end

  // term stage
  assign s_ext = {sample[SAMPLE_WIDTH-1], sample};
  assign mag   = s_ext[SAMPLE_WIDTH] ? (SAMPLE_WIDTH+1)'(-s_ext) : s_ext;
  assign sq    = SQW'(mag) * SQW'(mag);

  always_comb begin
    case (operation)
      OP_ASUM:  term_d = TW'(mag);
      OP_SUMSQ: term_d = TW'(sq >> 8);
      default:  term_d = TW'(sample);
    endcase
  end

  assign cnt_inc     = {1'b0, count} + (LEN_W+1)'(1);
  assign status.last = cnt_inc >= {1'b0, glen};
  assign status.mean = operation == OP_MEAN;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_vld <= 1'b0;
      count    <= '0;
    end else begin
      term_vld <= cmd.take;
      if (cmd.take) begin
        count <= status.last ? '0 : cnt_inc[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      term_q <= term_d;
    end
  end

  // saturating accumulator
  assign sum = SUMW'(acc) + SUMW'(term_q);

  always_comb begin
    if (sum > SUM_MAX) begin
      acc_next = ACC_MAX;
    end else if (sum < SUM_MIN) begin
      acc_next = ACC_MIN;
    end else begin
      acc_next = sum[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.mag_load) begin
      acc <= '0;
    end else if (term_vld) begin
      acc <= acc_next;
    end
  end

  // sign and magnitude split, then two partial products on one multiplier
  assign acc_mag   = acc[ACC_WIDTH-1] ? ACC_WIDTH'(-acc) : ACC_WIDTH'(acc);
  assign scale_mag = scale[COEF_W-1] ? COEF_W'(-scale) : COEF_W'(scale);
  assign mul_a     = cmd.mul_hi ? am[MAGW-1:MUL_W] : am[MUL_W-1:0];
  assign mul_p     = MAGW'(mul_a) * MAGW'(sm);

  always_ff @(posedge clk) begin
    if (cmd.mag_load) begin
      am  <= MAGW'(acc_mag);
      sm  <= scale_mag;
      neg <= acc[ACC_WIDTH-1] ^ scale[COEF_W-1];
    end
    if (cmd.mul_lo) begin
      p_lo <= mul_p;
    end
    if (cmd.mul_hi) begin
      p_hi <= mul_p;
    end
    if (cmd.prod_load) begin
      prod <= {p_hi, {MUL_W{1'b0}}} + PROD_W'(p_lo);
    end
    if (cmd.rnd_load) begin
      qr <= QW'(prod[PROD_W-1:COEF_FRAC]) + QW'(rnd_up);
    end
  end

  // round toward minus infinity on negative results
  assign rnd_up = neg && (prod[COEF_FRAC-1:0] != '0);

  // clip and restore sign
  assign lim   = neg ? LIM_NEG : LIM_POS;
  assign sat_d = qr > lim;
  assign qsel  = sat_d ? lim : qr;
  assign res   = neg ? ACC_WIDTH'(-qsel[ACC_WIDTH-1:0]) : qsel[ACC_WIDTH-1:0];

  // output register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value     <= res;
      saturated <= sat_d;
    end
  end

endmodule

/* hw/rtl/grs_ctrl.sv */
// -----------------------------------------------------------------------------
// grs_ctrl
// sequencer for sample intake, scale division and group result formation
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module grs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  grs_pkg::status_t status,
  output grs_pkg::cmd_t    cmd
);
  import grs_pkg::*;

  localparam int STEP_W = $clog2(COEF_W);

  typedef enum logic [3:0] {
    S_RUN,
    S_DINIT,
    S_DIV,
    S_DFIN,
    S_LAST,
    S_MAG,
    S_MUL0,
    S_MUL1,
    S_SUM,
    S_RND,
    S_SAT
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    // no writes while a group result is being formed
    cfg_ready     = (state == S_RUN) || (state == S_DINIT) ||
                    (state == S_DIV) || (state == S_DFIN);
    cmd.cfg_write = cfg_valid && cfg_ready;
    in_ready      = (state == S_RUN) && !cfg_valid;
    cmd.take      = in_valid && in_ready;
    unique case (state)
      S_RUN: begin
        if (cfg_valid) begin
          state_next = S_DINIT;
        end else if (cmd.take && status.last) begin
          state_next = S_LAST;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        if (cfg_valid) begin
          state_next = S_DINIT;
        end else if (status.mean) begin
          state_next = S_DIV;
          step_next  = STEP_W'(COEF_W - 1);
        end else begin
          state_next = S_RUN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cfg_valid) begin
          state_next = S_DINIT;
        end else if (step == '0) begin
          state_next = S_DFIN;
        end else begin
          step_next = step - STEP_W'(1);
        end
      end
      S_DFIN: begin
        cmd.scale_load = 1'b1;
        state_next     = cfg_valid ? S_DINIT : S_RUN;
      end
      S_LAST: begin
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag_load = 1'b1;
        state_next   = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.prod_load = 1'b1;
        state_next    = S_RND;
      end
      S_RND: begin
        cmd.rnd_load = 1'b1;
        state_next   = S_SAT;
      end
      S_SAT: begin
        cmd.out_load = status.out_free;
        if (status.out_free) begin
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  `ASSERT_IMPLY(a_last_after_take, clk, rst, state == S_LAST, $past(cmd.take && status.last))
  `ASSERT_IMPLY(a_load_free_slot, clk, rst, cmd.out_load, status.out_free)
  `ASSERT_IMPLY(a_divide_in_mean, clk, rst, state == S_DIV, status.mean)
  `ASSERT_NEXT(a_hold_after_last, clk, rst, cmd.take && status.last, !in_ready)

endmodule

/* hw/rtl/group_reduction_sum_asum_sumsq.sv */
// -----------------------------------------------------------------------------
// group_reduction_sum_asum_sumsq
// Reduces signed Q8.8 samples in groups of group_length as a sum, a mean, a
// sum of absolute values or a sum of squares, and returns each group's total
// times the signed Q8.24 coefficient, clipped to the value width with a flag.
// Within a group one sample is taken per cycle. After the last sample of a
// group the input is held off from S_LAST through S_SAT while the result is
// formed on one shared 32x32 multiplier in two partial products, and for
// longer if the previous result has not yet been taken; configuration writes
// wait over the same stretch. Input is refused during a configuration write
// and in S_DINIT after it, in mean mode also in S_DIV and S_DFIN, where the
// scale is divided by the group length one quotient bit a cycle.
// -----------------------------------------------------------------------------
module group_reduction_sum_asum_sumsq #(
  parameter int          SAMPLE_WIDTH = grs_pkg::SAMPLE_WIDTH_DEF,
  parameter int          ACC_WIDTH    = grs_pkg::ACC_WIDTH_DEF,
  parameter int unsigned MAX_GROUP    = grs_pkg::MAX_GROUP_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic signed [ACC_WIDTH-1:0]    value,
  output logic                           saturated,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [grs_pkg::IDX_W-1:0]      cfg_index,
  input  logic [grs_pkg::CFG_W-1:0]      cfg_data
);
  import grs_pkg::*;

  cmd_t    cmd;
  status_t status;

  grs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  grs_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH),
    .MAX_GROUP    (MAX_GROUP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .saturated (saturated)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// Checks the group reduction block against a cycle-free predictor of its
// arithmetic. Samples and configuration writes go in through valid/ready
// with random idling on both sides. A scoreboard folds each accepted sample
// into its own accumulator, queues the scaled group total when a group closes
// and compares every returned transaction field by field. A directed opener
// covers the field extremes, every operation, a zero group length and a
// write landing mid-group. Random phases with changing settings follow,
// then a short run under an oversize group length.
// -----------------------------------------------------------------------------
module tb_top;
  import grs_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 48;

  typedef struct packed {
    logic signed [ACC_WIDTH_DEF-1:0] value;
    logic                            saturated;
  } group_result_t;

  class group_sum_scoreboard;
    op_t                             op_mode;
    logic signed [COEF_W-1:0]        coef;
    logic [LEN_W-1:0]                grp_len;
    logic signed [ACC_WIDTH_DEF-1:0] acc;
    logic [LEN_W-1:0]                count;
    logic signed [COEF_W-1:0]        scale;
    group_result_t                   pending[$];
    int                              mismatches;

    function new();
      op_mode    = OP_SUM;
      coef       = COEF_RESET;
      grp_len    = 17'd1;
      acc        = '0;
      count      = '0;
      mismatches = 0;
      rescale();
    endfunction

    function int unsigned eff_len();
      int unsigned n;
      n = 32'(grp_len);
      if (n == 0) n = 1;
      if (n > MAX_GROUP_DEF) n = MAX_GROUP_DEF;
      return n;
    endfunction

    function void rescale();
      if (op_mode == OP_MEAN) begin
        scale = COEF_W'(longint'(coef) / longint'(eff_len()));
      end else begin
        scale = coef;
      end
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_OPERATION: begin
          op_mode = op_t'(data[OP_W-1:0]);
        end
        REG_COEFFICIENT: begin
          coef = data;
        end
        REG_GROUP_LENGTH: begin
          grp_len = data[LEN_W-1:0];
        end
        default: begin
          return;
        end
      endcase
      rescale();
    endfunction

    function void note_sample(logic signed [SAMPLE_WIDTH_DEF-1:0] smp);
      longint s;
      longint mag;
      longint term;
      longint a;
      logic signed [79:0] prod;
      logic signed [79:0] q;
      group_result_t r;
      s    = longint'(smp);
      mag  = (s < 0) ? -s : s;
      case (op_mode)
        OP_ASUM:  term = mag;
        OP_SUMSQ: term = (mag * mag) >>> 8;
        default:  term = s;
      endcase
      a = longint'(acc) + term;
      if (a > 64'sh0000_7FFF_FFFF_FFFF) a = 64'sh0000_7FFF_FFFF_FFFF;
      else if (a < -64'sh0000_8000_0000_0000) a = -64'sh0000_8000_0000_0000;
      acc   = a[ACC_WIDTH_DEF-1:0];
      count = count + 1'b1;
      if (count < eff_len()) return;
      // Q8.8 times Q8.24, floor back to Q8.8
      prod = 80'(acc) * 80'(scale);
      q    = prod >>> 24;
      r.saturated = 1'b0;
      if (q > 80'sh7FFF_FFFF_FFFF) begin
        q = 80'sh7FFF_FFFF_FFFF;
        r.saturated = 1'b1;
      end else if (q < -80'sh8000_0000_0000) begin
        q = -80'sh8000_0000_0000;
        r.saturated = 1'b1;
      end
      r.value = q[ACC_WIDTH_DEF-1:0];
      pending = {pending, r};
      acc   = '0;
      count = '0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic signed [ACC_WIDTH_DEF-1:0] v, logic sat);
      group_result_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d sat=%0b", v, sat));
        return;
      end
      e = pending.pop_front();
      if (v !== e.value)
        report_mismatch($sformatf("value %0d, predicted %0d", v, e.value));
      if (sat !== e.saturated)
        report_mismatch($sformatf("saturated %0b, predicted %0b", sat, e.saturated));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic signed [SAMPLE_WIDTH_DEF-1:0] sample;
  logic in_valid;
  logic in_ready;
  logic signed [ACC_WIDTH_DEF-1:0] value;
  logic saturated;
  logic out_valid;
  logic out_ready;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic no_idle;

  group_sum_scoreboard sb = new();

  group_reduction_sum_asum_sumsq DUT (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .saturated (saturated),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(value, saturated);
  end

  task automatic send_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] s);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    sample   <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic send_setting(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // drain every outstanding result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input op_t op, input logic [CFG_W-1:0] coef,
                           input logic [LEN_W-1:0] len);
    settle();
    send_setting(REG_OPERATION, CFG_W'(op));
    send_setting(REG_COEFFICIENT, coef);
    send_setting(REG_GROUP_LENGTH, CFG_W'(len));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    case (r % 10)
      0: if (r < 10) return 16'sh7FFF;
      1: if (r < 10) return 16'sh8000;
      2: if (r < 10) return 16'sh0000;
      3: if (r < 10) return 16'shFFFF;
      default: ;
    endcase
    return SAMPLE_WIDTH_DEF'($urandom());
  endfunction

  function automatic logic [CFG_W-1:0] pick_coef();
    case ($urandom_range(24))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0100_0000;
      4: return 32'hFF00_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int items_sent;
    int r;
    int unsigned len;
    int unsigned eff;
    int unsigned n;
    rst       = 1'b1;
    sample    = '0;
    in_valid  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: plain sum, unit scale, groups of one
    send_sample(16'sh0000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);
    // most negative sample taken by magnitude
    configure(OP_ASUM, 32'hFF00_0000, 17'd2);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    configure(OP_SUMSQ, 32'h7FFF_FFFF, 17'd3);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    configure(OP_MEAN, 32'h8000_0000, 17'd4);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'shFFFF);
    send_sample(16'sh3039);
    // zero length behaves as one
    configure(OP_SUM, 32'h0000_0000, 17'd0);
    send_sample(16'sh0064);
    send_sample(16'shFF9C);
    // shorten the group after three of five samples
    configure(OP_MEAN, 32'h0100_0000, 17'd5);
    send_sample(16'sh1234);
    send_sample(16'shEDCB);
    send_sample(16'sh7FFF);
    settle();
    send_setting(REG_GROUP_LENGTH, CFG_W'(17'd2));
    send_setting(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_sample(16'sh0101);

    while (items_sent < 1800) begin
      no_idle = (items_sent >= 700 && items_sent < 1100);
      r = $urandom_range(99);
      if (r < 5) len = 0;
      else if (r < 65) len = $urandom_range(8, 1);
      else if (r < 90) len = $urandom_range(64, 9);
      else len = $urandom_range(400, 65);
      eff = (len == 0) ? 1 : len;
      n = $urandom_range((eff >= 48) ? 1 : 48 / eff, 1) * eff;
      if ($urandom_range(3) == 0) n += $urandom_range(eff - 1, 0);
      if (items_sent + int'(n) > 1800) n = 1800 - items_sent;
      configure(op_t'($urandom_range(3)), pick_coef(), LEN_W'(len));
      repeat (n) send_sample(pick_sample());
      items_sent += int'(n);
    end
    no_idle = 1'b0;

    // length field above the largest group
    configure(OP_SUM, pick_coef(), 17'h1_FFFF);
    repeat (40) send_sample(pick_sample());

    settle();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* group_reduction_sum_asum_sumsq.f */
+incdir+hw/rtl
hw/rtl/grs_pkg.sv
hw/rtl/grs_dp.sv
hw/rtl/grs_ctrl.sv
hw/rtl/group_reduction_sum_asum_sumsq.sv
verif/tb_top.sv
